// File: src/diag_response_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diagnostic response parser
// Property wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DIAG_RESPONSE_PARSER_UNIT_ASSERT_SVH
`define DIAG_RESPONSE_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define DRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/drp_pkg.sv
// ----------------------------------------------------------------------------
// Diagnostic response parser package
// Byte role codes, component type codes, the net address bound and the result record shared by the parser modules.
// ----------------------------------------------------------------------------
package drp_pkg;

    localparam logic [3:0] ROLE_VER_MAJOR  = 4'd0;
    localparam logic [3:0] ROLE_VER_MINOR  = 4'd1;
    localparam logic [3:0] ROLE_SOCKET_HI  = 4'd2;
    localparam logic [3:0] ROLE_SOCKET_LO  = 4'd3;
    localparam logic [3:0] ROLE_COMP_COUNT = 4'd4;
    localparam logic [3:0] ROLE_SIMPLE     = 4'd5;
    localparam logic [3:0] ROLE_ROUTER     = 4'd6;
    localparam logic [3:0] ROLE_UNKNOWN    = 4'd7;
    localparam logic [3:0] ROLE_NET_COUNT  = 4'd8;
    localparam logic [3:0] ROLE_NET_TYPE   = 4'd9;
    localparam logic [3:0] ROLE_NET_ADDR   = 4'd10;
    localparam logic [3:0] ROLE_TRAILING   = 4'd11;

    // Component type codes.
    localparam logic [7:0] TYPE_ROUTER_LO  = 8'd5;
    localparam logic [7:0] TYPE_ROUTER_HI  = 8'd7;
    localparam logic [7:0] TYPE_SIMPLE_MAX = 8'd4;
    localparam logic [7:0] TYPE_SIMPLE_ALT = 8'd9;

    // Last byte position within a net address.
    localparam logic [3:0] ADDR_LAST = 4'd9;

    typedef struct packed {
        logic [3:0] byte_role;
        logic [7:0] byte_value;
        logic [7:0] component_index;
        logic [7:0] net_index;
        logic [3:0] address_offset;
        logic       truncated;
        logic       packet_end;
    } result_t;

endpackage

// File: src/drp_classifier.sv
// ----------------------------------------------------------------------------
// Diagnostic response parser classifier
// Holds the parse state and labels each accepted byte in one pass.
// ----------------------------------------------------------------------------
module drp_classifier (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output drp_pkg::result_t res
);

    typedef enum logic [3:0] {
        PH_VMAJ, PH_VMIN, PH_SHI, PH_SLO, PH_CCNT,
        PH_CTYPE, PH_NCNT, PH_NTYPE, PH_NADDR, PH_TRAIL
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] comp_left_reg, comp_left_next;
    logic [7:0] comp_cnt_reg, comp_cnt_next;
    logic [7:0] nets_left_reg, nets_left_next;
    logic [7:0] net_cnt_reg, net_cnt_next;
    logic [3:0] addr_cnt_reg, addr_cnt_next;

    always_comb begin
        phase_t nph;
        logic   is_router;
        logic   is_simple;
        nph            = PH_TRAIL;
        comp_left_next = comp_left_reg;
        comp_cnt_next  = comp_cnt_reg;
        nets_left_next = nets_left_reg;
        net_cnt_next   = net_cnt_reg;
        addr_cnt_next  = addr_cnt_reg;
        is_router = (data_byte >= drp_pkg::TYPE_ROUTER_LO) &&
                    (data_byte <= drp_pkg::TYPE_ROUTER_HI);
        is_simple = (data_byte <= drp_pkg::TYPE_SIMPLE_MAX) ||
                    (data_byte == drp_pkg::TYPE_SIMPLE_ALT);

        res.byte_role       = drp_pkg::ROLE_TRAILING;
        res.byte_value      = data_byte;
        res.component_index = 8'd0;
        res.net_index       = 8'd0;
        res.address_offset  = 4'd0;
        res.packet_end      = last_byte;

        case (phase_reg)
            PH_VMAJ: begin
                res.byte_role = drp_pkg::ROLE_VER_MAJOR;
                nph = PH_VMIN;
            end
            PH_VMIN: begin
                res.byte_role = drp_pkg::ROLE_VER_MINOR;
                nph = PH_SHI;
            end
            PH_SHI: begin
                res.byte_role = drp_pkg::ROLE_SOCKET_HI;
                nph = PH_SLO;
            end
            PH_SLO: begin
                res.byte_role = drp_pkg::ROLE_SOCKET_LO;
                nph = PH_CCNT;
            end
            PH_CCNT: begin
                res.byte_role  = drp_pkg::ROLE_COMP_COUNT;
                comp_left_next = data_byte;
                comp_cnt_next  = 8'd0;
                nph = (data_byte != 8'd0) ? PH_CTYPE : PH_TRAIL;
            end
            PH_CTYPE: begin
                res.component_index = comp_cnt_reg;
                if (is_router) begin
                    res.byte_role = drp_pkg::ROLE_ROUTER;
                    nph = PH_NCNT;
                end else begin
                    res.byte_role = is_simple ? drp_pkg::ROLE_SIMPLE
                                              : drp_pkg::ROLE_UNKNOWN;
                    comp_left_next = comp_left_reg - 8'd1;
                    comp_cnt_next  = comp_cnt_reg + 8'd1;
                    nph = (comp_left_reg != 8'd1) ? PH_CTYPE : PH_TRAIL;
                end
            end
            PH_NCNT: begin
                res.byte_role       = drp_pkg::ROLE_NET_COUNT;
                res.component_index = comp_cnt_reg;
                nets_left_next      = data_byte;
                net_cnt_next        = 8'd0;
                if (data_byte != 8'd0) begin
                    nph = PH_NTYPE;
                end else begin
                    comp_left_next = comp_left_reg - 8'd1;
                    comp_cnt_next  = comp_cnt_reg + 8'd1;
                    nph = (comp_left_reg != 8'd1) ? PH_CTYPE : PH_TRAIL;
                end
            end
            PH_NTYPE: begin
                res.byte_role       = drp_pkg::ROLE_NET_TYPE;
                res.component_index = comp_cnt_reg;
                res.net_index       = net_cnt_reg;
                addr_cnt_next       = 4'd0;
                nph = PH_NADDR;
            end
            PH_NADDR: begin
                res.byte_role       = drp_pkg::ROLE_NET_ADDR;
                res.component_index = comp_cnt_reg;
                res.net_index       = net_cnt_reg;
                res.address_offset  = addr_cnt_reg;
                if (addr_cnt_reg >= drp_pkg::ADDR_LAST) begin
                    // End of this net; possibly also the end of the component.
                    nets_left_next = nets_left_reg - 8'd1;
                    net_cnt_next   = net_cnt_reg + 8'd1;
                    if (nets_left_reg != 8'd1) begin
                        nph = PH_NTYPE;
                    end else begin
                        comp_left_next = comp_left_reg - 8'd1;
                        comp_cnt_next  = comp_cnt_reg + 8'd1;
                        nph = (comp_left_reg != 8'd1) ? PH_CTYPE : PH_TRAIL;
                    end
                end else begin
                    addr_cnt_next = addr_cnt_reg + 4'd1;
                    nph = PH_NADDR;
                end
            end
            default: begin
                res.byte_role = drp_pkg::ROLE_TRAILING;
                nph = PH_TRAIL;
            end
        endcase

        res.truncated = last_byte && (nph != PH_TRAIL);
        phase_next    = nph;

        // The final byte of a packet sends the parser back to its start state.
        if (last_byte) begin
            phase_next     = PH_VMAJ;
            comp_left_next = 8'd0;
            comp_cnt_next  = 8'd0;
            nets_left_next = 8'd0;
            net_cnt_next   = 8'd0;
            addr_cnt_next  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_VMAJ;
            comp_left_reg <= 8'd0;
            comp_cnt_reg  <= 8'd0;
            nets_left_reg <= 8'd0;
            net_cnt_reg   <= 8'd0;
            addr_cnt_reg  <= 4'd0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            comp_left_reg <= comp_left_next;
            comp_cnt_reg  <= comp_cnt_next;
            nets_left_reg <= nets_left_next;
            net_cnt_reg   <= net_cnt_next;
            addr_cnt_reg  <= addr_cnt_next;
        end
    end

endmodule

// File: src/drp_out_buffer.sv
// ----------------------------------------------------------------------------
// Diagnostic response parser output buffer
// Result register with a skid entry so one more input byte is taken under a stall.
// ----------------------------------------------------------------------------
module drp_out_buffer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  drp_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output drp_pkg::result_t out_data
);

    drp_pkg::result_t main_reg;
    drp_pkg::result_t skid_reg;
    logic             main_valid_reg;
    logic             skid_valid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || out_ready) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                // Main register is held by a stalled transfer; park the new result.
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

// File: src/diag_response_parser_unit.sv
// ----------------------------------------------------------------------------
// Diagnostic response parser
// Labels each byte of a diagnostic reply payload with its structural role.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one payload byte per transfer (s_data_byte) with
//   s_last_byte set on the final byte of a packet. The m_ channel returns one
//   result per input byte, in order: its role, the byte itself, component and
//   net indexes, the offset within a net address, a truncated flag and a
//   copy of the end mark.
//   Each accepted byte's result is registered into the output stage; it goes
//   to the m_ ports unless an older result still waits there. Throughput is
//   one byte per cycle while the output stage has room.
//   A two-entry output stage lets one more byte in while a result waits on
//   m_ready; with both entries full, s_ready drops until the receiver takes
//   a result.
//   Reset (aresetn low at a clock edge) empties the output stage and sets
//   the parser to the first header byte. The parser also returns there after
//   every byte that carries s_last_byte.
// ----------------------------------------------------------------------------
`include "diag_response_parser_unit_assert.svh"

module diag_response_parser_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_byte_role,
    output logic [7:0] m_byte_value,
    output logic [7:0] m_component_index,
    output logic [7:0] m_net_index,
    output logic [3:0] m_address_offset,
    output logic       m_truncated,
    output logic       m_packet_end
);

    drp_pkg::result_t cls_res;
    drp_pkg::result_t out_res;
    logic             in_accept;

    assign in_accept = s_valid && s_ready;

    drp_classifier u_classifier (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .res       (cls_res)
    );

    drp_out_buffer u_out_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (cls_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_byte_role       = out_res.byte_role;
    assign m_byte_value      = out_res.byte_value;
    assign m_component_index = out_res.component_index;
    assign m_net_index       = out_res.net_index;
    assign m_address_offset  = out_res.address_offset;
    assign m_truncated       = out_res.truncated;
    assign m_packet_end      = out_res.packet_end;

    `DRP_ASSERT_IMPL(a_trunc_only_at_end, aclk, aresetn, m_valid && m_truncated, m_packet_end)
    `DRP_ASSERT_IMPL(a_offset_only_in_addr, aclk, aresetn,
        m_valid && (m_byte_role != drp_pkg::ROLE_NET_ADDR), m_address_offset == 4'd0)
    `DRP_ASSERT_IMPL(a_offset_in_range, aclk, aresetn,
        m_valid, m_address_offset <= drp_pkg::ADDR_LAST)
    `DRP_ASSERT_IMPL(a_stall_means_full, aclk, aresetn, !s_ready, m_valid)
    `DRP_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, in_accept, m_valid)

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Diagnostic response parser testbench
// Feeds directed and random reply packets through the parser, predicts the
// full result of every byte and checks each result transfer against it, with
// random idling on both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        ST_VER_MAJOR, ST_VER_MINOR, ST_SOCKET_HI, ST_SOCKET_LO, ST_COMP_COUNT,
        ST_COMP_TYPE, ST_NET_COUNT, ST_NET_TYPE, ST_NET_ADDR, ST_TRAILING
    } parse_state_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_byte_role;
    logic [7:0] m_byte_value;
    logic [7:0] m_component_index;
    logic [7:0] m_net_index;
    logic [3:0] m_address_offset;
    logic       m_truncated;
    logic       m_packet_end;

    // Parser state as the byte labeller sees it.
    parse_state_t parse_state = ST_VER_MAJOR;
    logic [7:0]   comps_left = 8'd0;
    logic [7:0]   comp_idx = 8'd0;
    logic [7:0]   nets_left = 8'd0;
    logic [7:0]   net_idx = 8'd0;
    logic [3:0]   addr_pos = 4'd0;

    drp_pkg::result_t expected_labels[$];
    logic [7:0]       packet_bytes[$];
    int               items_sent = 0;
    int               fail_count = 0;
    bit               no_idle = 1'b0;
    int               stall_request = 0;
    int               hold_left = 0;

    diag_response_parser_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_byte_role       (m_byte_role),
        .m_byte_value      (m_byte_value),
        .m_component_index (m_component_index),
        .m_net_index       (m_net_index),
        .m_address_offset  (m_address_offset),
        .m_truncated       (m_truncated),
        .m_packet_end      (m_packet_end)
    );

    always #5 aclk = ~aclk;

    function automatic void reset_parser();
        parse_state = ST_VER_MAJOR;
        comps_left = 8'd0;
        comp_idx = 8'd0;
        nets_left = 8'd0;
        net_idx = 8'd0;
        addr_pos = 4'd0;
    endfunction

    function automatic parse_state_t finish_component();
        comps_left = comps_left - 8'd1;
        comp_idx = comp_idx + 8'd1;
        return (comps_left != 8'd0) ? ST_COMP_TYPE : ST_TRAILING;
    endfunction

    function automatic drp_pkg::result_t label_byte(input logic [7:0] b,
                                                    input logic is_last);
        drp_pkg::result_t r;
        parse_state_t     nxt;
        r = '0;
        r.byte_value = b;
        r.packet_end = is_last;
        r.byte_role = drp_pkg::ROLE_TRAILING;
        nxt = ST_TRAILING;
        case (parse_state)
            ST_VER_MAJOR: begin
                r.byte_role = drp_pkg::ROLE_VER_MAJOR;
                nxt = ST_VER_MINOR;
            end
            ST_VER_MINOR: begin
                r.byte_role = drp_pkg::ROLE_VER_MINOR;
                nxt = ST_SOCKET_HI;
            end
            ST_SOCKET_HI: begin
                r.byte_role = drp_pkg::ROLE_SOCKET_HI;
                nxt = ST_SOCKET_LO;
            end
            ST_SOCKET_LO: begin
                r.byte_role = drp_pkg::ROLE_SOCKET_LO;
                nxt = ST_COMP_COUNT;
            end
            ST_COMP_COUNT: begin
                r.byte_role = drp_pkg::ROLE_COMP_COUNT;
                comps_left = b;
                comp_idx = 8'd0;
                nxt = (b != 8'd0) ? ST_COMP_TYPE : ST_TRAILING;
            end
            ST_COMP_TYPE: begin
                r.component_index = comp_idx;
                if (b >= drp_pkg::TYPE_ROUTER_LO && b <= drp_pkg::TYPE_ROUTER_HI) begin
                    r.byte_role = drp_pkg::ROLE_ROUTER;
                    nxt = ST_NET_COUNT;
                end else begin
                    r.byte_role = (b <= drp_pkg::TYPE_SIMPLE_MAX ||
                                   b == drp_pkg::TYPE_SIMPLE_ALT) ?
                                  drp_pkg::ROLE_SIMPLE : drp_pkg::ROLE_UNKNOWN;
                    nxt = finish_component();
                end
            end
            ST_NET_COUNT: begin
                r.byte_role = drp_pkg::ROLE_NET_COUNT;
                r.component_index = comp_idx;
                nets_left = b;
                net_idx = 8'd0;
                nxt = (b != 8'd0) ? ST_NET_TYPE : finish_component();
            end
            ST_NET_TYPE: begin
                r.byte_role = drp_pkg::ROLE_NET_TYPE;
                r.component_index = comp_idx;
                r.net_index = net_idx;
                addr_pos = 4'd0;
                nxt = ST_NET_ADDR;
            end
            ST_NET_ADDR: begin
                r.byte_role = drp_pkg::ROLE_NET_ADDR;
                r.component_index = comp_idx;
                r.net_index = net_idx;
                r.address_offset = addr_pos;
                if (addr_pos >= drp_pkg::ADDR_LAST) begin
                    nets_left = nets_left - 8'd1;
                    net_idx = net_idx + 8'd1;
                    nxt = (nets_left != 8'd0) ? ST_NET_TYPE : finish_component();
                end else begin
                    addr_pos = addr_pos + 4'd1;
                    nxt = ST_NET_ADDR;
                end
            end
            default: begin
                r.byte_role = drp_pkg::ROLE_TRAILING;
                nxt = ST_TRAILING;
            end
        endcase
        r.truncated = is_last && (nxt != ST_TRAILING);
        if (is_last) begin
            reset_parser();
        end else begin
            parse_state = nxt;
        end
        return r;
    endfunction

    // Labels every accepted byte, then checks any result transfer of this edge.
    always @(posedge aclk) begin
        drp_pkg::result_t want;
        if (!aresetn) begin
            reset_parser();
        end else begin
            if (s_valid && s_ready) begin
                expected_labels.push_back(label_byte(s_data_byte, s_last_byte));
            end
            if (m_valid && m_ready) begin
                if (expected_labels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: role %0d value %02h", m_byte_role,
                                 m_byte_value);
                    end
                end else begin
                    want = expected_labels.pop_front();
                    if (m_byte_role !== want.byte_role || m_byte_value !== want.byte_value
                        || m_component_index !== want.component_index
                        || m_net_index !== want.net_index
                        || m_address_offset !== want.address_offset
                        || m_truncated !== want.truncated
                        || m_packet_end !== want.packet_end) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch exp: role %0d val %02h comp %0d net %0d %s",
                                     want.byte_role, want.byte_value, want.component_index,
                                     want.net_index, $sformatf("addr %0d trunc %0b end %0b",
                                     want.address_offset, want.truncated,
                                     want.packet_end));
                            $display("         got: role %0d val %02h comp %0d net %0d %s",
                                     m_byte_role, m_byte_value, m_component_index,
                                     m_net_index, $sformatf("addr %0d trunc %0b end %0b",
                                     m_address_offset, m_truncated, m_packet_end));
                        end
                    end
                end
            end
        end
    end

    // Result side: random idling, plus long stalls counted out here.
    always @(posedge aclk) begin
        if (stall_request != 0) begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!no_idle && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_packet();
        foreach (packet_bytes[i]) begin
            send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
        end
    endtask

    // Builds a well-formed reply with random content, cut short at times.
    function automatic void build_packet(input int max_len);
        int  comps;
        int  nets;
        int  pick;
        int  cut;
        bit  complete;
        packet_bytes.delete();
        repeat (4) packet_bytes.push_back(8'($urandom_range(255)));
        pick = $urandom_range(99);
        comps = (pick < 5) ? 0 : (pick < 10) ? $urandom_range(4, 255) : $urandom_range(1, 3);
        packet_bytes.push_back(8'(comps));
        complete = 1'b1;
        for (int c = 0; c < comps && complete; c++) begin
            if (packet_bytes.size() >= max_len) begin
                complete = 1'b0;
            end else begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    packet_bytes.push_back(drp_pkg::TYPE_ROUTER_LO +
                                           8'($urandom_range(2)));
                    nets = ($urandom_range(99) < 10) ? $urandom_range(3, 255) :
                           $urandom_range(0, 2);
                    packet_bytes.push_back(8'(nets));
                    for (int n = 0; n < nets && complete; n++) begin
                        if (packet_bytes.size() >= max_len) begin
                            complete = 1'b0;
                        end else begin
                            repeat (11) packet_bytes.push_back(8'($urandom_range(255)));
                        end
                    end
                end else if (pick < 75) begin
                    pick = $urandom_range(0, 5);
                    packet_bytes.push_back((pick == 5) ? drp_pkg::TYPE_SIMPLE_ALT
                                                       : 8'(pick));
                end else begin
                    pick = $urandom_range(drp_pkg::TYPE_ROUTER_HI + 1, 255);
                    packet_bytes.push_back((pick == drp_pkg::TYPE_SIMPLE_ALT) ? 8'd8
                                                                             : 8'(pick));
                end
            end
        end
        if (!complete || $urandom_range(99) < 25) begin
            cut = $urandom_range(1, packet_bytes.size());
            while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
        end else begin
            repeat ($urandom_range(0, 2)) packet_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic run_packets(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 20) begin
                packet_bytes.delete();
                repeat ($urandom_range(1, 8)) packet_bytes.push_back(8'($urandom_range(255)));
            end else begin
                build_packet(($urandom_range(99) < 5) ? 120 : 48);
            end
            send_packet();
        end
    endtask

    // Short header, zero component count with a trailing byte, each type
    // class with a zero net count, and a packet cut at a net type byte.
    task automatic test_directed_packets();
        packet_bytes = '{8'hFF, 8'h00};
        send_packet();
        packet_bytes = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h00, 8'h80};
        send_packet();
        packet_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h03, drp_pkg::TYPE_SIMPLE_ALT,
                         8'hFF, drp_pkg::TYPE_ROUTER_LO, 8'h00};
        send_packet();
        packet_bytes = '{8'h7F, 8'h80, 8'h01, 8'hFE, 8'h01, drp_pkg::TYPE_ROUTER_HI,
                         8'h02, 8'h11};
        send_packet();
    endtask

    // The result side stops for a long time while bytes keep coming, so the
    // output stage fills and the input must stall.
    task automatic test_output_backpressure();
        no_idle = 1'b1;
        stall_request = 60;
        run_packets(30);
        no_idle = 1'b0;
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_packets(60);
        no_idle = 1'b0;
    endtask

    task automatic test_random_packets();
        run_packets(300);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_packets();
        test_output_backpressure();
        test_back_to_back();
        test_random_packets();
        s_valid <= 1'b0;
        while (expected_labels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
